### design/rkt_pkg.sv
// shared types, constants and helpers of the rssi kalman tracker
`timescale 1ns / 1ps
package rkt_pkg;

  localparam int unsigned AGENT_COUNT = 16;

  localparam logic [1:0] SLOT_FOLLOWER = 2'd0;
  localparam logic [1:0] SLOT_LEADER   = 2'd1;
  localparam logic [1:0] SLOT_BASE     = 2'd2;
  localparam logic [1:0] SLOT_RAW      = 2'd3;

  localparam logic OP_PEER = 1'b0;
  localparam logic OP_BASE = 1'b1;

  localparam logic [2:0] CFG_FOLLOWER_ID  = 3'd0;
  localparam logic [2:0] CFG_LEADER_ID    = 3'd1;
  localparam logic [2:0] CFG_SPEED_GAIN   = 3'd2;
  localparam logic [2:0] CFG_PROCESS_NOISE = 3'd3;
  localparam logic [2:0] CFG_MEASURE_NOISE = 3'd4;
  localparam logic [2:0] CFG_COOLDOWN     = 3'd5;

  typedef struct packed {
    logic [1:0]         slot;
    logic               raw_ok;
    logic [7:0]         rssi;
    logic signed [15:0] speed;
    logic [31:0]        now;
  } item_t;

  typedef struct packed {
    logic signed [15:0] speed_gain;
    logic [31:0]        process_noise;
    logic [31:0]        measure_noise;
    logic [15:0]        cooldown;
  } filt_cfg_t;

  typedef struct packed {
    logic [1:0]         slot;
    logic               updated;
    logic signed [23:0] estimate;
    logic [31:0]        covariance;
    logic [31:0]        stamp;
  } result_t;

  function automatic logic signed [23:0] sat24(input logic signed [31:0] x);
    logic signed [23:0] r;
    if (x > 32'sd8388607) begin
      r = 24'sh7fffff;
    end else if (x < -32'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

endpackage

### design/rkt_front.sv
// front end: accepts reports, picks the slot, queues them for the filter engine
`timescale 1ns / 1ps
module rkt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [3:0]        source_id_i,
  input  logic [7:0]        rssi_value_i,
  input  logic signed [15:0] speed_i,
  input  logic [31:0]       now_tick_i,
  input  logic [3:0]        follower_id_i,
  input  logic [3:0]        leader_id_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output rkt_pkg::item_t    q_item_o
);

  rkt_pkg::item_t entry_q [2];
  logic [1:0] count_q, count_d;
  logic wr_ptr_q, rd_ptr_q;
  logic push;
  rkt_pkg::item_t cls;

  always_comb begin
    cls.rssi   = rssi_value_i;
    cls.speed  = speed_i;
    cls.now    = now_tick_i;
    cls.raw_ok = ({1'b0, source_id_i} < 5'(rkt_pkg::AGENT_COUNT));
    if (operation_i == rkt_pkg::OP_BASE) begin
      cls.slot = rkt_pkg::SLOT_BASE;
    end else if (source_id_i == follower_id_i) begin
      cls.slot = rkt_pkg::SLOT_FOLLOWER;
    end else if (source_id_i == leader_id_i) begin
      cls.slot = rkt_pkg::SLOT_LEADER;
    end else begin
      cls.slot = rkt_pkg::SLOT_RAW;
    end
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !q_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
  a_no_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> count_q != 2'd0) else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

endmodule

### design/rkt_div.sv
// restoring divider for the kalman gain, one quotient bit per cycle
`timescale 1ns / 1ps
module rkt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] pcov_i,
  input  logic [32:0] den_i,
  output logic        done_o,
  output logic [16:0] gain_o
);

  logic [32:0] rem_q;
  logic [32:0] den_q;
  logic [16:0] quo_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [33:0] rem2;
  logic        fits;

  assign rem2 = {rem_q, 1'b0};
  assign fits = (rem2 >= {1'b0, den_q});
  assign done_o = done_q;
  assign gain_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (den_i == 33'd0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= 5'd16;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      if (den_i == 33'd0) begin
        quo_q <= 17'd0;
        rem_q <= 33'd0;
      end else if ({1'b0, pcov_i} >= den_i) begin
        quo_q <= 17'd1;
        rem_q <= {1'b0, pcov_i} - den_i;
      end else begin
        quo_q <= 17'd0;
        rem_q <= {1'b0, pcov_i};
      end
    end else if (busy_q) begin
      quo_q <= {quo_q[15:0], fits};
      rem_q <= fits ? 33'(rem2 - {1'b0, den_q}) : rem2[32:0];
    end
  end

endmodule

### design/rkt_back.sv
// back end: runs the three scalar filters and holds the result register
`timescale 1ns / 1ps
module rkt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  rkt_pkg::item_t     q_item_i,
  input  rkt_pkg::filt_cfg_t cfg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rkt_pkg::result_t   out_res_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLS   = 4'd1;
  localparam logic [3:0] S_MULS  = 4'd2;
  localparam logic [3:0] S_PRED  = 4'd3;
  localparam logic [3:0] S_DIVGO = 4'd4;
  localparam logic [3:0] S_DIVW  = 4'd5;
  localparam logic [3:0] S_MULE  = 4'd6;
  localparam logic [3:0] S_MULC  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_q, state_d;

  logic signed [23:0] est_q [3];
  logic [31:0]        cov_q [3];
  logic [31:0]        stp_q [3];

  rkt_pkg::item_t   it_q;
  rkt_pkg::result_t res_q, res_d;
  rkt_pkg::result_t out_q;
  logic             out_valid_q;

  logic signed [31:0] sprod_q;
  logic signed [23:0] pred_q;
  logic [31:0]        pcov_q;
  logic [16:0]        gain_q;
  logic signed [43:0] eprod_q;
  logic [48:0]        cprod_q;

  logic [1:0]         idx;
  logic signed [23:0] cur_est;
  logic [31:0]        cur_cov, cur_stp, elapsed;
  logic signed [23:0] z;
  logic signed [31:0] spd_term, pred_sum;
  logic [32:0]        pcov_sum;
  logic [31:0]        pcov;
  logic signed [25:0] innov;
  logic signed [27:0] corr;
  logic signed [31:0] new_est_sum;
  logic [32:0]        cov_drop;
  logic               div_done;
  logic [16:0]        div_gain;
  logic               out_free;
  logic               wr_state;

  assign idx      = (it_q.slot == rkt_pkg::SLOT_RAW) ? rkt_pkg::SLOT_FOLLOWER : it_q.slot;
  assign cur_est  = est_q[idx];
  assign cur_cov  = cov_q[idx];
  assign cur_stp  = stp_q[idx];
  assign elapsed  = it_q.now - cur_stp;
  assign z        = {8'd0, it_q.rssi, 8'd0};
  assign out_free = !out_valid_q || out_ready_i;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;

  // prediction: rounded speed term, saturating add, covariance growth
  assign spd_term = 32'((sprod_q + 32'sd2048) >>> 12);
  assign pred_sum = 32'(cur_est) + spd_term;
  assign pcov_sum = {1'b0, cur_cov} + {1'b0, cfg_i.process_noise};
  assign pcov     = pcov_sum[32] ? 32'hffff_ffff : pcov_sum[31:0];

  // correction
  assign innov       = 26'(z) - 26'(pred_q);
  assign corr        = 28'((eprod_q + 44'sd32768) >>> 16);
  assign new_est_sum = 32'(pred_q) + 32'(corr);
  assign cov_drop    = 33'((cprod_q + 49'd32768) >> 16);

  rkt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == S_DIVGO),
    .pcov_i (pcov_q),
    .den_i  ({1'b0, pcov_q} + {1'b0, cfg_i.measure_noise}),
    .done_o (div_done),
    .gain_o (div_gain)
  );

  always_comb begin
    state_d  = state_q;
    res_d    = res_q;
    wr_state = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          state_d = S_CLS;
        end
      end
      S_CLS: begin
        res_d.slot = it_q.slot;
        state_d    = S_OUT;
        if (it_q.slot == rkt_pkg::SLOT_RAW) begin
          res_d.updated    = it_q.raw_ok;
          res_d.estimate   = it_q.raw_ok ? z : 24'sd0;
          res_d.covariance = 32'd0;
          res_d.stamp      = it_q.raw_ok ? it_q.now : 32'd0;
        end else if (cur_est == 24'sd0) begin
          // empty filter takes the measurement as it is
          wr_state         = 1'b1;
          res_d.updated    = 1'b1;
          res_d.estimate   = z;
          res_d.covariance = cfg_i.measure_noise;
          res_d.stamp      = it_q.now;
        end else if (elapsed > {16'd0, cfg_i.cooldown}) begin
          state_d = S_MULS;
        end else begin
          res_d.updated    = 1'b0;
          res_d.estimate   = cur_est;
          res_d.covariance = cur_cov;
          res_d.stamp      = cur_stp;
        end
      end
      S_MULS:  state_d = S_PRED;
      S_PRED:  state_d = S_DIVGO;
      S_DIVGO: state_d = S_DIVW;
      S_DIVW: begin
        if (div_done) begin
          state_d = S_MULE;
        end
      end
      S_MULE:  state_d = S_MULC;
      S_MULC:  state_d = S_FIN;
      S_FIN: begin
        wr_state         = 1'b1;
        res_d.updated    = 1'b1;
        res_d.estimate   = rkt_pkg::sat24(new_est_sum);
        res_d.covariance = 32'(33'(pcov_q) - cov_drop);
        res_d.stamp      = it_q.now;
        state_d          = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        est_q[i] <= 24'sd0;
        cov_q[i] <= 32'd0;
        stp_q[i] <= 32'd0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (wr_state) begin
        est_q[idx] <= res_d.estimate;
        cov_q[idx] <= res_d.covariance;
        stp_q[idx] <= res_d.stamp;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (q_pop_o) begin
      it_q <= q_item_i;
    end
    if (state_q == S_MULS) begin
      sprod_q <= 32'(cfg_i.speed_gain) * 32'(it_q.speed);
    end
    if (state_q == S_PRED) begin
      pred_q <= rkt_pkg::sat24(pred_sum);
      pcov_q <= pcov;
    end
    if (div_done) begin
      gain_q <= div_gain;
    end
    if (state_q == S_MULE) begin
      eprod_q <= 44'($signed({1'b0, gain_q}) * innov);
    end
    if (state_q == S_MULC) begin
      cprod_q <= 49'(gain_q) * 49'(pcov_q);
    end
    if (state_q == S_OUT && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

### design/rssi_kalman_tracker_top.sv
// top level of the rssi kalman tracker: config registers, front end and filter engine
`timescale 1ns / 1ps
// Takes one rssi report per beat and answers each with exactly one result beat, in
// order. Base link reports feed the base filter; peer reports from the follower id
// feed the follower filter (it wins when follower and leader ids match), from the
// leader id the leader filter, and all others come back as raw values stamped with
// their tick. A filter update walks a sequencer through the speed product, the
// prediction, a 17-step restoring divider for the gain and two correction products
// before it writes the filter state and offers its result; raw reports, first
// reports and cooldown skips go from the classify state straight to the output
// state. The engine takes the next report only once it has handed its result to
// the result register, and the divider sets the update time. A two-entry queue in
// front lets reports arrive while the engine works, and a result register lets the
// engine finish while the sink stalls. Config writes are taken at once and must
// only happen while the block is idle.
module rssi_kalman_tracker_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [3:0]         source_id_i,
  input  logic [7:0]         rssi_value_i,
  input  logic signed [15:0] speed_i,
  input  logic [31:0]        now_tick_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         slot_o,
  output logic               updated_o,
  output logic signed [23:0] estimate_o,
  output logic [31:0]        covariance_o,
  output logic [31:0]        stamp_o
);

  logic [3:0]         follower_id_q, leader_id_q;
  rkt_pkg::filt_cfg_t fcfg_q;
  logic               q_valid, q_pop;
  rkt_pkg::item_t     q_item;
  rkt_pkg::result_t   res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      follower_id_q        <= 4'd0;
      leader_id_q          <= 4'd1;
      fcfg_q.speed_gain    <= 16'sd0;
      fcfg_q.process_noise <= 32'd65536;
      fcfg_q.measure_noise <= 32'd65536;
      fcfg_q.cooldown      <= 16'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rkt_pkg::CFG_FOLLOWER_ID:   follower_id_q        <= cfg_wdata_i[3:0];
        rkt_pkg::CFG_LEADER_ID:     leader_id_q          <= cfg_wdata_i[3:0];
        rkt_pkg::CFG_SPEED_GAIN:    fcfg_q.speed_gain    <= cfg_wdata_i[15:0];
        rkt_pkg::CFG_PROCESS_NOISE: fcfg_q.process_noise <= cfg_wdata_i;
        rkt_pkg::CFG_MEASURE_NOISE: fcfg_q.measure_noise <= cfg_wdata_i;
        rkt_pkg::CFG_COOLDOWN:      fcfg_q.cooldown      <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // accept and route
  rkt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .source_id_i  (source_id_i),
    .rssi_value_i (rssi_value_i),
    .speed_i      (speed_i),
    .now_tick_i   (now_tick_i),
    .follower_id_i(follower_id_q),
    .leader_id_i  (leader_id_q),
    .q_valid_o    (q_valid),
    .q_pop_i      (q_pop),
    .q_item_o     (q_item)
  );

  // filter engine with result register
  rkt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_item_i   (q_item),
    .cfg_i      (fcfg_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (res)
  );

  assign slot_o       = res.slot;
  assign updated_o    = res.updated;
  assign estimate_o   = res.estimate;
  assign covariance_o = res.covariance;
  assign stamp_o      = res.stamp;

endmodule
